/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* rtl/mrd_pkg.sv */
// ----------------------------------------------------------------------------
// mrd_pkg
// types and constants shared by the mean rgb distance unit
// ----------------------------------------------------------------------------
`default_nettype none

package mrd_pkg;

  // pixel counter range
  localparam int unsigned PIXEL_COUNT_BITS = 20;
  localparam int unsigned CNT_W            = PIXEL_COUNT_BITS + 1;

  // distance: 16 fraction bits, 65536 means 1.0
  localparam int unsigned DIST_W    = 17;
  localparam int unsigned SUM_W     = DIST_W + PIXEL_COUNT_BITS;
  localparam int unsigned TOTAL_W   = 21;

  // sum of squared channel differences and its scale 3 * 255 * 255
  localparam int unsigned SQ_W       = 18;
  localparam logic [SQ_W-1:0] DIST_DENOM = 18'd195075;
  localparam logic [DIST_W-1:0] DIST_ONE = 17'd65536;

  // fraction bits shifted into the scaled square sum, and the width of the
  // root search terms: S * 2^32 and d^2 * 3 * 255^2 both stay below 2^52
  localparam int unsigned FRAC_SH    = 32;
  localparam int unsigned SCALE_W    = 52;
  localparam int unsigned ROOT_STEPS = DIST_W;

  // entry of the queue between front and back
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              last;
  } mrd_item_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_ROOT,
    FRONT_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIV,
    BACK_DONE
  } back_state_e;

endpackage

`default_nettype wire

/* rtl/mrd_front.sv */
// ----------------------------------------------------------------------------
// mrd_front
// takes pixel pairs and works out the per-pixel distance, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_front import mrd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [47:0] in_data_i,
  input  wire logic        in_last_i,
  output logic             push_o,
  output mrd_item_t        push_item_o,
  input  wire logic        full_i
);

  front_state_e state_q, state_d;
  logic               last_q, last_d;
  logic [SCALE_W-1:0] tgt_q, tgt_d;
  logic [SCALE_W-1:0] acc_q, acc_d;
  logic [SCALE_W-1:0] lin_q, lin_d;
  logic [SCALE_W-1:0] sqr_q, sqr_d;
  logic [DIST_W-1:0]  res_q, res_d;
  logic [DIST_W-1:0]  bit_q, bit_d;

  // squared channel differences of the incoming pair
  logic [7:0]      dr, dg, db;
  logic [SQ_W-1:0] sq_in;

  always_comb begin
    dr = (in_data_i[7:0] >= in_data_i[31:24]) ? in_data_i[7:0] - in_data_i[31:24]
                                               : in_data_i[31:24] - in_data_i[7:0];
    dg = (in_data_i[15:8] >= in_data_i[39:32]) ? in_data_i[15:8] - in_data_i[39:32]
                                                : in_data_i[39:32] - in_data_i[15:8];
    db = (in_data_i[23:16] >= in_data_i[47:40]) ? in_data_i[23:16] - in_data_i[47:40]
                                                 : in_data_i[47:40] - in_data_i[23:16];
    sq_in = SQ_W'(16'(dr * dr)) + SQ_W'(16'(dg * dg)) + SQ_W'(16'(db * db));
  end

  // one root step: acc holds d^2 * denom, lin holds d * denom shifted past the
  // current bit, sqr holds denom times the current bit squared
  logic [SCALE_W-1:0] trial;
  logic               take;

  always_comb begin
    trial = acc_q + lin_q + sqr_q;
    take  = trial <= tgt_q;
  end

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    tgt_d       = tgt_q;
    acc_d       = acc_q;
    lin_d       = lin_q;
    sqr_d       = sqr_q;
    res_d       = res_q;
    bit_d       = bit_q;
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    push_item_o = '{distance: res_q, last: last_q};
    unique case (state_q)
      FRONT_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          tgt_d   = SCALE_W'(sq_in) << FRAC_SH;
          last_d  = in_last_i;
          acc_d   = '0;
          lin_d   = '0;
          sqr_d   = SCALE_W'(DIST_DENOM) << (2 * (ROOT_STEPS - 1));
          res_d   = '0;
          bit_d   = {1'b1, {(DIST_W-1){1'b0}}};
          state_d = FRONT_ROOT;
        end
      end
      FRONT_ROOT: begin
        // keep the bit when the squared candidate still fits under S * 2^32
        if (take) begin
          acc_d = trial;
          lin_d = (lin_q >> 1) + sqr_q;
          res_d = res_q | bit_q;
        end else begin
          lin_d = lin_q >> 1;
        end
        sqr_d = sqr_q >> 2;
        bit_d = bit_q >> 1;
        if (bit_q[0]) begin
          state_d = FRONT_PUSH;
        end
      end
      FRONT_PUSH: begin
        push_o = 1'b1;
        if (!full_i) begin
          state_d = FRONT_IDLE;
        end
      end
      default: state_d = FRONT_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    tgt_q  <= tgt_d;
    acc_q  <= acc_d;
    lin_q  <= lin_d;
    sqr_q  <= sqr_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
  end

endmodule

`default_nettype wire

/* rtl/mrd_fifo.sv */
// ----------------------------------------------------------------------------
// mrd_fifo
// two-entry queue of distances between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_fifo import mrd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  mrd_item_t  push_item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output mrd_item_t  pop_item_o
);

  mrd_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  always_comb begin
    full_o     = cnt_q == 2'd2;
    empty_o    = cnt_q == 2'd0;
    do_push    = push_i && !full_o;
    do_pop     = pop_i && !empty_o;
    pop_item_o = mem_q[rd_ptr_q];
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/mrd_back.sv */
// ----------------------------------------------------------------------------
// mrd_back
// accumulates distances, divides out the mean and holds the result
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mrd_back import mrd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         empty_i,
  input  mrd_item_t         pop_item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [DIST_W-1:0] out_mean_o,
  output logic [TOTAL_W-1:0] out_total_o,
  output logic              out_sat_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] MAX_COUNT = {1'b1, {PIXEL_COUNT_BITS{1'b0}}};

  back_state_e state_q, state_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              sat_q, sat_d;
  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic              dsat_q, dsat_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              ovalid_q, ovalid_d;
  logic [DIST_W-1:0] omean_q, omean_d;
  logic [TOTAL_W-1:0] ototal_q, ototal_d;
  logic              osat_q, osat_d;

  // accumulator update for the item at the head of the queue
  logic              cnt_full;
  logic [SUM_W-1:0]  sum_nx;
  logic [CNT_W-1:0]  cnt_nx;
  logic              sat_nx;

  always_comb begin
    cnt_full = cnt_q == MAX_COUNT;
    sum_nx   = cnt_full ? sum_q : sum_q + SUM_W'(pop_item_i.distance);
    cnt_nx   = cnt_full ? cnt_q : cnt_q + 1'b1;
    sat_nx   = sat_q | cnt_full;
  end

  // restoring division step
  logic [CNT_W:0] div_sh;
  logic           div_ge;

  always_comb begin
    div_sh = {rem_q, dvd_q[SUM_W-1]};
    div_ge = div_sh >= {1'b0, dvs_q};
  end

  // next state and datapath
  always_comb begin
    state_d  = state_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    sat_d    = sat_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    dsat_d   = dsat_q;
    step_d   = step_q;
    omean_d  = omean_q;
    ototal_d = ototal_q;
    osat_d   = osat_q;
    ovalid_d = ovalid_q && !out_ready_i;
    pop_o    = 1'b0;
    unique case (state_q)
      BACK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (pop_item_i.last) begin
            // hand the totals to the divider and start a new image
            dvd_d   = sum_nx;
            dvs_d   = cnt_nx;
            dsat_d  = sat_nx;
            rem_d   = '0;
            step_d  = STEP_W'(SUM_W - 1);
            sum_d   = '0;
            cnt_d   = '0;
            sat_d   = 1'b0;
            state_d = BACK_DIV;
          end else begin
            sum_d = sum_nx;
            cnt_d = cnt_nx;
            sat_d = sat_nx;
          end
        end
      end
      BACK_DIV: begin
        rem_d  = div_ge ? CNT_W'(div_sh - {1'b0, dvs_q}) : div_sh[CNT_W-1:0];
        dvd_d  = {dvd_q[SUM_W-2:0], div_ge};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = BACK_DONE;
        end
      end
      BACK_DONE: begin
        // load the output register once it is free
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          omean_d  = dvd_q[DIST_W-1:0];
          ototal_d = TOTAL_W'(dvs_q);
          osat_d   = dsat_q;
          state_d  = BACK_IDLE;
        end
      end
      default: state_d = BACK_IDLE;
    endcase
  end

  // control state and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BACK_IDLE;
      sum_q    <= '0;
      cnt_q    <= '0;
      sat_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      sat_q    <= sat_d;
      ovalid_q <= ovalid_d;
    end
  end

  // divider and result registers
  always_ff @(posedge clk_i) begin
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    dsat_q   <= dsat_d;
    step_q   <= step_d;
    omean_q  <= omean_d;
    ototal_q <= ototal_d;
    osat_q   <= osat_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_mean_o  = omean_q;
  assign out_total_o = ototal_q;
  assign out_sat_o   = osat_q;

  `ASSERT_NEVER(a_cnt_max, clk_i, rst_ni, cnt_q > MAX_COUNT, "pixel count above maximum")
  `ASSERT_PROP(a_div_nonzero, clk_i, rst_ni, state_q == BACK_DIV |-> dvs_q != '0, "zero divisor")
  `ASSERT_PROP(a_mean_range, clk_i, rst_ni, state_q == BACK_DONE |-> dvd_q <= SUM_W'(DIST_ONE), "mean above one")

endmodule

`default_nettype wire

/* rtl/mean_rgb_distance_unit.sv */
// ----------------------------------------------------------------------------
// mean_rgb_distance_unit
// mean per-pixel rms rgb distance between a rendered and a target image
// ----------------------------------------------------------------------------
// The front takes a new pixel pair only once it has pushed the one before.
// It accepts a pair and forms the sum S of squared channel differences, finds
// the distance one result bit a cycle (each step tests d^2 * 3 * 255^2 <=
// S * 2^32 with shifts and adds only), and pushes it into a two-entry queue.
// The back adds each distance to the sum as it leaves the queue. On the pixel
// marked last it divides sum by count bit-serially and loads mean, count and
// saturation flag into an output register once that register is free. The
// queue covers most of the divide; the front stalls only once the queue fills,
// for instance while a result waits for the sink and a further last pixel
// follows.
`default_nettype none

module mean_rgb_distance_unit import mrd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // rendered_red, rendered_green, rendered_blue, target_red, target_green, target_blue
  input  wire logic [47:0] s_axis_tdata,
  // last_pixel
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // mean_distance [16:0], pixel_total [37:17], zero padding [39:38]
  output logic [39:0]      m_axis_tdata,
  // count_saturated
  output logic             m_axis_tuser
);

  logic              push, full, pop, empty;
  mrd_item_t         push_item, pop_item;
  logic [DIST_W-1:0] mean;
  logic [TOTAL_W-1:0] total;

  // distance front
  mrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  // queue between front and back
  mrd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_item_o  (pop_item)
  );

  // accumulate and average
  mrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_mean_o  (mean),
    .out_total_o (total),
    .out_sat_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, total, mean};

endmodule

`default_nettype wire
